@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CHK_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Port check failed.");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Port check failed.");

`endif

@@ sv/smrb_pkg.sv @@
`timescale 1ns / 1ps

package smrb_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int COUNT_W      = 32;
    localparam int CH_W         = 2;
    localparam int MAX_CHANNELS = 3;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 80;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [CH_W-1:0]     t_channel;

    typedef struct packed {
        logic    tick;
        logic    pop;
        t_sample sample;
    } t_ring_ctl;

    typedef struct packed {
        logic    nonempty;
        t_sample rd_data;
        t_count  stored;
        t_count  dropped;
    } t_ring_stat;

endpackage

@@ sv/smrb_ring.sv @@
`timescale 1ns / 1ps

module smrb_ring #(
    parameter int DEPTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smrb_pkg::t_ring_ctl   i_ctl,
    output smrb_pkg::t_ring_stat  o_stat
);

    localparam int PW = $clog2(2 * DEPTH);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] P_LAST  = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] P_DEPTH = PW'(DEPTH);
    localparam logic [PW-1:0] P_SPAN  = PW'(2 * DEPTH);

    smrb_pkg::t_sample r_mem [DEPTH];
    smrb_pkg::t_sample r_rd_data;

    logic [PW-1:0]    r_wp, r_rp, n_wp, n_rp;
    smrb_pkg::t_count r_stored, r_dropped, n_stored, n_dropped;

    logic [PW-1:0] w_fill;
    logic          w_full, w_empty, w_do_write, w_do_read;
    logic [AW-1:0] w_wslot, w_rslot;

    always_comb begin
        w_fill     = (r_wp >= r_rp) ? r_wp - r_rp : r_wp - r_rp + P_SPAN;
        w_full     = (w_fill >= P_DEPTH);
        w_empty    = (r_wp == r_rp);
        w_do_write = i_ctl.tick && !w_full;
        w_do_read  = i_ctl.pop && !w_empty;
        w_wslot    = AW'((r_wp >= P_DEPTH) ? r_wp - P_DEPTH : r_wp);
        w_rslot    = AW'((r_rp >= P_DEPTH) ? r_rp - P_DEPTH : r_rp);

        n_wp      = r_wp;
        n_rp      = r_rp;
        n_stored  = r_stored;
        n_dropped = r_dropped;
        if (w_do_write) begin
            n_wp     = (r_wp == P_LAST) ? '0 : r_wp + 1'b1;
            n_stored = r_stored + 1'b1;
        end
        if (i_ctl.tick && w_full) begin
            n_dropped = r_dropped + 1'b1;
        end
        if (w_do_read) begin
            n_rp = (r_rp == P_LAST) ? '0 : r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_stored  <= '0;
            r_dropped <= '0;
        end else begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_stored  <= n_stored;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_mem[w_wslot] <= i_ctl.sample;
        end
        if (w_do_read) begin
            r_rd_data <= r_mem[w_rslot];
        end
    end

    assign o_stat.nonempty = !w_empty;
    assign o_stat.rd_data  = r_rd_data;
    assign o_stat.stored   = r_stored;
    assign o_stat.dropped  = r_dropped;

endmodule

@@ sv/multichannel_sample_ring_buffer.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata                               tuser
// s_axis    in         sample_a, sample_b, sample_c, chan  func
// m_axis    out        popped_sample, accepted, overrun    data_valid
//
// Each transfer updates the rings at the input edge and the result is shown on m_axis
// in the next cycle, so one item per cycle is sustained while m_axis_tready is high.
// Every channel has its own ring memory with one write and one read port.
// Reset is synchronous and clears pointers, counters and the output valid.
// The output register holds a result until taken; s_axis stalls during reset and while
// the output register is full and m_axis_tready is low.
module multichannel_sample_ring_buffer #(
    parameter int RING_DEPTH = 512,
    parameter int CHANNELS   = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_a [11:0], sample_b [23:12], sample_c [35:24], channel [37:36], zero fill
    input  logic [smrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func [0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // popped_sample [11:0], accepted_count [43:12], overrun_count [75:44], zero fill
    output logic [smrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // data_valid [0]
    output logic [0:0]                        m_axis_tuser
);

    smrb_pkg::t_sample    w_samp [smrb_pkg::MAX_CHANNELS];
    smrb_pkg::t_channel   w_in_ch;
    smrb_pkg::t_ring_stat w_stat [smrb_pkg::MAX_CHANNELS];
    smrb_pkg::t_ring_stat w_in_stat, w_out_stat;
    logic                 w_acc, w_tick, w_pop;

    logic                 r_out_valid;
    logic                 r_dv, n_dv;
    smrb_pkg::t_channel   r_ch;

    assign w_samp[0] = s_axis_tdata[11:0];
    assign w_samp[1] = s_axis_tdata[23:12];
    assign w_samp[2] = s_axis_tdata[35:24];
    assign w_in_ch   = s_axis_tdata[37:36];

    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_tick = w_acc && (s_axis_tuser[0] == smrb_pkg::FUNC_TICK);
    assign w_pop  = w_acc && (s_axis_tuser[0] == smrb_pkg::FUNC_POP);

    for (genvar g = 0; g < smrb_pkg::MAX_CHANNELS; g++) begin : g_ch
        if (g < CHANNELS) begin : g_ring
            smrb_pkg::t_ring_ctl w_ctl;
            assign w_ctl.tick   = w_tick;
            assign w_ctl.pop    = w_pop && (w_in_ch == smrb_pkg::CH_W'(g));
            assign w_ctl.sample = w_samp[g];

            smrb_ring #(
                .DEPTH (RING_DEPTH)
            ) u_ring (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .o_stat  (w_stat[g])
            );
        end else begin : g_absent
            assign w_stat[g] = '0;
        end
    end

    always_comb begin
        w_in_stat  = '0;
        w_out_stat = '0;
        for (int k = 0; k < smrb_pkg::MAX_CHANNELS; k++) begin
            if (w_in_ch == smrb_pkg::CH_W'(k)) begin
                w_in_stat = w_stat[k];
            end
            if (r_ch == smrb_pkg::CH_W'(k)) begin
                w_out_stat = w_stat[k];
            end
        end
        n_dv = w_pop && w_in_stat.nonempty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_dv <= n_dv;
            r_ch <= w_in_ch;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_dv;
    assign m_axis_tdata  = {4'b0000, w_out_stat.dropped, w_out_stat.stored,
                            r_dv ? w_out_stat.rd_data : smrb_pkg::t_sample'(0)};

endmodule

@@ sv/smrb_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smrb_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [smrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [0:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [smrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                        m_axis_tuser
);

    logic w_s_acc, w_m_stall, w_s_tick, w_s_absent, w_m_no_data;

    assign w_s_acc     = s_axis_tvalid && s_axis_tready;
    assign w_m_stall   = m_axis_tvalid && !m_axis_tready;
    assign w_s_tick    = w_s_acc && (s_axis_tuser[0] == smrb_pkg::FUNC_TICK);
    assign w_s_absent  = w_s_acc && (s_axis_tdata[37:36] == 2'd3);
    assign w_m_no_data = m_axis_tvalid && !m_axis_tuser[0];

    `CHK_NEXT(a_out_held, i_clk, i_rst_n, w_m_stall, m_axis_tvalid)
    `CHK_NEXT(a_result_follows, i_clk, i_rst_n, w_s_acc, m_axis_tvalid)
    `CHK_NEXT(a_tick_no_data, i_clk, i_rst_n, w_s_tick, m_axis_tuser[0] == 1'b0)
    `CHK_NOW(a_sample_zero, i_clk, i_rst_n, w_m_no_data, m_axis_tdata[11:0] == 12'd0)
    `CHK_NEXT(a_absent_counts, i_clk, i_rst_n, w_s_absent, m_axis_tdata[75:12] == 64'd0)

endmodule

bind multichannel_sample_ring_buffer smrb_chk u_smrb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ dv/multichannel_sample_ring_buffer_tb.sv @@
`timescale 1ns / 1ps

module multichannel_sample_ring_buffer_tb;

    localparam int RING_DEPTH   = 512;
    localparam int CHANNELS     = 3;
    localparam int PTR_W        = $clog2(2 * RING_DEPTH);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_LIMIT  = 50;
    localparam smrb_pkg::t_channel ABSENT_CHANNEL = 2'd3;

    typedef struct {
        logic              data_valid;
        smrb_pkg::t_sample popped_sample;
        smrb_pkg::t_count  accepted_count;
        smrb_pkg::t_count  overrun_count;
    } t_ring_reply;

    class ring_tracker;
        smrb_pkg::t_sample slots[CHANNELS][RING_DEPTH];
        logic [PTR_W-1:0]  wr_ptr[CHANNELS];
        logic [PTR_W-1:0]  rd_ptr[CHANNELS];
        smrb_pkg::t_count  stored[CHANNELS];
        smrb_pkg::t_count  dropped[CHANNELS];
        t_ring_reply       awaited_replies[$];
        int                mismatches;
        int                ticks;
        int                pops;
        int                hits;
        smrb_pkg::t_count  peak_dropped;

        function new();
            for (int i = 0; i < CHANNELS; i++) begin
                wr_ptr[i]  = '0;
                rd_ptr[i]  = '0;
                stored[i]  = '0;
                dropped[i] = '0;
            end
            mismatches   = 0;
            ticks        = 0;
            pops         = 0;
            hits         = 0;
            peak_dropped = '0;
        endfunction

        function logic [PTR_W-1:0] fill_of(int ch);
            return wr_ptr[ch] - rd_ptr[ch];
        endfunction

        function void take_item(logic func, smrb_pkg::t_sample a, smrb_pkg::t_sample b,
                                smrb_pkg::t_sample c, smrb_pkg::t_channel ch);
            t_ring_reply       r;
            smrb_pkg::t_sample s[3];
            s[0] = a;
            s[1] = b;
            s[2] = c;
            r.data_valid    = 1'b0;
            r.popped_sample = '0;
            if (func == smrb_pkg::FUNC_TICK) begin
                ticks++;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (fill_of(i) < RING_DEPTH) begin
                        slots[i][wr_ptr[i] % RING_DEPTH] = s[i];
                        wr_ptr[i]++;
                        stored[i]++;
                    end else begin
                        dropped[i]++;
                        if (dropped[i] > peak_dropped) begin
                            peak_dropped = dropped[i];
                        end
                    end
                end
            end else begin
                pops++;
                if (ch < CHANNELS && fill_of(ch) != 0) begin
                    r.data_valid    = 1'b1;
                    r.popped_sample = slots[ch][rd_ptr[ch] % RING_DEPTH];
                    rd_ptr[ch]++;
                    hits++;
                end
            end
            r.accepted_count = (ch < CHANNELS) ? stored[ch] : '0;
            r.overrun_count  = (ch < CHANNELS) ? dropped[ch] : '0;
            awaited_replies.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("Mismatch at %0t: %s, got 0x%0h, expected 0x%0h.", $realtime, what,
                         got, want);
            end
        endtask

        task check_result(logic dv, logic [smrb_pkg::OUT_TDATA_W-1:0] td);
            t_ring_reply want;
            if (awaited_replies.size() == 0) begin
                report_mismatch("result with nothing outstanding", 32'(td[11:0]), 32'd0);
            end else begin
                want = awaited_replies.pop_front();
                if (dv !== want.data_valid) begin
                    report_mismatch("data_valid", 32'(dv), 32'(want.data_valid));
                end
                if (td[11:0] !== want.popped_sample) begin
                    report_mismatch("popped_sample", 32'(td[11:0]), 32'(want.popped_sample));
                end
                if (td[43:12] !== want.accepted_count) begin
                    report_mismatch("accepted_count", td[43:12], want.accepted_count);
                end
                if (td[75:44] !== want.overrun_count) begin
                    report_mismatch("overrun_count", td[75:44], want.overrun_count);
                end
            end
        endtask
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [smrb_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]                       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [smrb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                       m_axis_tuser;

    ring_tracker tracker = new();
    int          tx_idle_pct = 34;
    int          rx_idle_pct = 70;
    logic        hold_req    = 1'b0;
    int          cycle_count = 0;

    multichannel_sample_ring_buffer #(
        .RING_DEPTH(RING_DEPTH),
        .CHANNELS  (CHANNELS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit.");
            $display("multichannel_sample_ring_buffer_tb: errors");
            $finish;
        end
    end

    function automatic smrb_pkg::t_sample rand_sample();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        end
        return smrb_pkg::t_sample'($urandom_range(0, 4095));
    endfunction

    // The task returns at the edge where the transfer took place.
    task automatic offer_item(logic func, smrb_pkg::t_sample a, smrb_pkg::t_sample b,
                              smrb_pkg::t_sample c, smrb_pkg::t_channel ch);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ch, c, b, a};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_item(func, a, b, c, ch);
    endtask

    task automatic offer_random(int count, int tick_pct, int ch0_pct);
        logic               func;
        smrb_pkg::t_channel ch;
        for (int n = 0; n < count; n++) begin
            func = ($urandom_range(0, 99) < tick_pct) ? smrb_pkg::FUNC_TICK
                                                      : smrb_pkg::FUNC_POP;
            ch   = ($urandom_range(0, 99) < ch0_pct)
                   ? smrb_pkg::t_channel'(0)
                   : smrb_pkg::t_channel'($urandom_range(0, 3));
            offer_item(func, rand_sample(), rand_sample(), rand_sample(), ch);
        end
    endtask

    initial begin : result_side
        int hold_left  = 0;
        bit hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                tracker.check_result(m_axis_tuser[0], m_axis_tdata);
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_item(smrb_pkg::FUNC_POP,  12'h000, 12'h000, 12'h000, 2'd0);
        offer_item(smrb_pkg::FUNC_POP,  12'hFFF, 12'hFFF, 12'hFFF, ABSENT_CHANNEL);
        offer_item(smrb_pkg::FUNC_TICK, 12'h000, 12'hFFF, 12'hAAA, 2'd0);
        offer_item(smrb_pkg::FUNC_TICK, 12'hFFF, 12'h000, 12'h555, 2'd1);
        offer_item(smrb_pkg::FUNC_TICK, 12'h5A5, 12'hA5A, 12'hFFF, 2'd2);
        offer_item(smrb_pkg::FUNC_TICK, 12'h001, 12'h800, 12'h000, ABSENT_CHANNEL);
        repeat (5) offer_item(smrb_pkg::FUNC_POP, 12'h000, 12'h000, 12'h000, 2'd0);
        repeat (2) offer_item(smrb_pkg::FUNC_POP, 12'hFFF, 12'h000, 12'hFFF, 2'd1);
        offer_item(smrb_pkg::FUNC_POP, 12'h000, 12'h000, 12'h000, ABSENT_CHANNEL);
        repeat (5) offer_item(smrb_pkg::FUNC_POP, 12'h000, 12'hFFF, 12'h000, 2'd2);
        offer_item(smrb_pkg::FUNC_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 2'd1);
        repeat (3) offer_item(smrb_pkg::FUNC_POP, 12'h000, 12'h000, 12'h000, 2'd1);

        offer_random(600, 50, 0);

        tx_idle_pct = 70;
        rx_idle_pct <= 34;
        offer_random(650, 90, 0);

        // The result side stalls for a long stretch while transfers keep being offered.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
        offer_random(600, 15, 80);

        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d capture ticks and %0d pops, %0d of which returned a sample.",
                 tracker.ticks, tracker.pops, tracker.hits);
        $display("Highest overrun count seen on any channel: %0d.", tracker.peak_dropped);
        if (tracker.mismatches == 0) begin
            $display("multichannel_sample_ring_buffer_tb: clean");
        end else begin
            $display("multichannel_sample_ring_buffer_tb: errors");
        end
        $finish;
    end

endmodule
